// File: sv/rmbh_pkg.sv
// Package for the rotate-multiply byte hash.
// Holds the word type, the initial hash values, the mixing constants and the
// control struct passed from the top level to the hash core. No dependencies.
package rmbh_pkg;

  localparam int unsigned NumWords = 8;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned WordW    = 32;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned RotLeft  = 5;
  localparam int unsigned RotRight = WordW - RotLeft;

  typedef logic [WordW-1:0] word_t;
  typedef logic [IdxW-1:0]  idx_t;
  typedef word_t            ring_t [NumWords];

  localparam word_t HashMult = 32'h5bd1e995;
  localparam idx_t  LastIdx  = idx_t'(NumWords - 1);

  localparam word_t InitWords [NumWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Control from the input stage to the hash core.
  typedef struct packed {
    logic             absorb;
    logic             restart;
    logic [ByteW-1:0] data;
  } core_ctl_t;

endpackage

// File: sv/rmbh_in_if.sv
// Input channel of the rotate-multiply byte hash: valid/ready plus one byte
// and the absorb/finish mode. Depends on nothing.
interface rmbh_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink (input valid, input mode, input data_byte, output ready);
endinterface

// File: sv/rmbh_out_if.sv
// Output channel of the rotate-multiply byte hash: valid/ready plus one digest
// word with its index and a last flag. Depends on nothing.
interface rmbh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

// File: sv/rmbh_core.sv
// Hash state of the rotate-multiply byte hash, kept as a ring of eight words
// with the current word always in slot 0. Depends on rmbh_pkg.
module rmbh_core
  import rmbh_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  core_ctl_t ctl_i,
  output ring_t     ring_o,
  output idx_t      pos_o
);

  ring_t ring_q, ring_d;
  idx_t  pos_q, pos_d;
  word_t mixed;
  word_t gained;

  // Rotate, XOR and multiply-add on the two front slots of the ring.
  assign mixed  = ((ring_q[0] << RotLeft) | (ring_q[0] >> RotRight))
                  ^ word_t'(ctl_i.data);
  assign gained = ring_q[1] + mixed * HashMult;

  // After an absorb the ring turns by one so the next word sits in slot 0.
  // The mixed word moves to the back of the ring.
  always_comb begin
    ring_d = ring_q;
    pos_d  = pos_q;
    if (ctl_i.restart) begin
      ring_d = InitWords;
      pos_d  = '0;
    end else if (ctl_i.absorb) begin
      for (int i = 1; i < NumWords - 1; i++) begin
        ring_d[i] = ring_q[i + 1];
      end
      ring_d[NumWords - 1] = mixed;
      ring_d[0]            = gained;
      pos_d                = pos_q + idx_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q <= InitWords;
      pos_q  <= '0;
    end else begin
      ring_q <= ring_d;
      pos_q  <= pos_d;
    end
  end

  assign ring_o = ring_q;
  assign pos_o  = pos_q;

endmodule

// File: sv/rotate_multiply_byte_hash.sv
// Rotate-multiply byte hash, top level: input register, hash core and digest
// buffer. Depends on rmbh_pkg, rmbh_in_if, rmbh_out_if and rmbh_core.
// Throughput: one byte transaction per cycle unless a finish waits on the buffer;
// the hash update is one rotate, XOR and 32-bit multiply-add from the input
// register into the word ring. With the buffer free, an accepted finish restarts
// the core as the buffer captures the ring, which shows word 0; its eight words
// leave one per cycle while ready is high. A further finish waits in the input
// register, holding off new transactions, until the last buffered word leaves.
// Reset loads the initial words, clears the byte counter and empties both stages.
module rotate_multiply_byte_hash
  import rmbh_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  rmbh_in_if.sink    in_i,
  rmbh_out_if.source out_o
);

  logic             stg_valid_q;
  logic             stg_mode_q;
  logic [ByteW-1:0] stg_byte_q;
  logic             stg_go;
  logic             buf_free;
  logic             buf_busy_q;
  idx_t             cnt_q;
  idx_t             rd_q;
  ring_t            buf_q;
  ring_t            ring;
  idx_t             pos;
  core_ctl_t        ctl;
  logic             out_last;

  // An absorb always leaves the input stage; a finish needs a free buffer.
  assign out_last  = (cnt_q == LastIdx);
  assign buf_free  = !buf_busy_q || (out_o.ready && out_last);
  assign stg_go    = stg_valid_q && (!stg_mode_q || buf_free);
  assign in_i.ready = !stg_valid_q || stg_go;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      stg_valid_q <= 1'b1;
    end else if (stg_go) begin
      stg_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      stg_mode_q <= in_i.mode;
      stg_byte_q <= in_i.data_byte;
    end
  end

  // Hash core.
  assign ctl.absorb  = stg_go && !stg_mode_q;
  assign ctl.restart = stg_go && stg_mode_q;
  assign ctl.data    = stg_byte_q;

  rmbh_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .ring_o (ring),
    .pos_o  (pos)
  );

  // Digest buffer: word i sits in ring slot (i - pos) mod 8 at capture.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_busy_q <= 1'b0;
      cnt_q      <= '0;
      rd_q       <= '0;
    end else if (ctl.restart) begin
      buf_busy_q <= 1'b1;
      cnt_q      <= '0;
      rd_q       <= idx_t'(0) - pos;
    end else if (buf_busy_q && out_o.ready) begin
      cnt_q <= cnt_q + idx_t'(1);
      rd_q  <= rd_q + idx_t'(1);
      if (out_last) begin
        buf_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.restart) begin
      buf_q <= ring;
    end
  end

  // Output transaction straight from the buffer registers.
  assign out_o.valid       = buf_busy_q;
  assign out_o.digest_word = buf_q[rd_q];
  assign out_o.word_index  = cnt_q;
  assign out_o.last_word   = out_last;

endmodule

// File: test/tb_top.sv
// Testbench for rotate_multiply_byte_hash: byte and finish transactions are
// checked against an in-bench model of the hash. Depends on rmbh_pkg,
// rmbh_in_if, rmbh_out_if and the rotate_multiply_byte_hash RTL.
module tb_top
  import rmbh_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ModeAbsorb = 1'b0;
  localparam logic ModeFinish = 1'b1;
  localparam int   RandomItems = 355;
  localparam int   MaxReports  = 10;

  typedef struct packed {
    word_t digest_word;
    idx_t  word_index;
    logic  last_word;
  } digest_beat_t;

  logic clk_i;
  logic rst_ni;

  rmbh_in_if  in_ch ();
  rmbh_out_if out_ch ();

  rotate_multiply_byte_hash dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Model state of the hash and the digest words still to come.
  word_t        hash_ring [NumWords];
  idx_t         byte_count;
  digest_beat_t digest_queue [$];

  int  error_count;
  int  items_sent;
  int  hold_request;
  bit  sender_gaps;
  bit  receiver_stalls;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
  end
  always #4 clk_i = ~clk_i;

  // Hard limit on the run time.
  initial begin
    #2ms;
    $display("tb_top: errors");
    $finish;
  end

  // Return the model to its initial words and a cleared byte counter.
  function automatic void restart_hash();
    for (int i = 0; i < NumWords; i++) begin
      hash_ring[i] = InitWords[i];
    end
    byte_count = '0;
  endfunction

  // Mix one message byte into the selected word and its successor.
  function automatic void absorb_byte(input logic [7:0] data);
    idx_t  k;
    idx_t  nxt;
    word_t w;
    k = byte_count;
    nxt = k + 1'b1;
    w = hash_ring[k];
    w = {w[WordW-RotLeft-1:0], w[WordW-1:WordW-RotLeft]} ^ word_t'(data);
    hash_ring[k] = w;
    hash_ring[nxt] = hash_ring[nxt] + w * HashMult;
    byte_count = byte_count + 1'b1;
  endfunction

  // Queue the eight digest words, then start a new message.
  function automatic void finish_message();
    digest_beat_t beat;
    for (int i = 0; i < NumWords; i++) begin
      beat.digest_word = hash_ring[i];
      beat.word_index  = idx_t'(i);
      beat.last_word   = (i == NumWords - 1);
      digest_queue.push_back(beat);
    end
    restart_hash();
  endfunction

  function automatic void note_error();
    error_count++;
  endfunction

  // Offer one transaction, with random gaps before it, and update the model
  // once it is accepted. Valid stays high afterwards for a following item.
  task automatic send_item(input logic mode, input logic [7:0] data);
    while (sender_gaps && $urandom_range(99) < 24) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= mode;
    in_ch.data_byte <= data;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
    if (mode == ModeFinish) begin
      finish_message();
    end else begin
      absorb_byte(data);
    end
  endtask

  // Stop offering and wait for every expected digest word.
  task automatic drain_digests();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (digest_queue.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_message(input int len, input logic [7:0] finish_byte);
    for (int i = 0; i < len; i++) begin
      send_item(ModeAbsorb, 8'($urandom_range(255)));
    end
    send_item(ModeFinish, finish_byte);
  endtask

  // Receiver: checks each accepted digest word and drives ready.
  initial begin : digest_sink
    int           hold_left;
    digest_beat_t seen;
    digest_beat_t want;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        seen.digest_word = out_ch.digest_word;
        seen.word_index  = out_ch.word_index;
        seen.last_word   = out_ch.last_word;
        if (digest_queue.size() == 0) begin
          note_error();
          if (error_count <= MaxReports) begin
            $display("unexpected digest word %h index %0d last %b",
                     seen.digest_word, seen.word_index, seen.last_word);
          end
        end else begin
          want = digest_queue.pop_front();
          if (seen.digest_word !== want.digest_word ||
              seen.word_index !== want.word_index ||
              seen.last_word !== want.last_word) begin
            note_error();
            if (error_count <= MaxReports) begin
              $display("digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                       want.digest_word, want.word_index, want.last_word,
                       seen.digest_word, seen.word_index, seen.last_word);
            end
          end
        end
      end
      // A long hold-off requested by a test is counted down here.
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (receiver_stalls) begin
        out_ch.ready <= ($urandom_range(99) >= 24);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // A finish with nothing absorbed returns the initial words.
  task automatic test_empty_message();
    send_item(ModeFinish, 8'h00);
    send_item(ModeFinish, 8'hff);
    drain_digests();
  endtask

  // Extreme and single-bit byte values in one message.
  task automatic test_byte_extremes();
    send_item(ModeAbsorb, 8'h00);
    send_item(ModeAbsorb, 8'hff);
    send_item(ModeAbsorb, 8'h80);
    send_item(ModeAbsorb, 8'h01);
    send_item(ModeAbsorb, 8'h55);
    send_item(ModeAbsorb, 8'haa);
    send_item(ModeFinish, 8'h5a);
    drain_digests();
  endtask

  // Byte counter wraps past the eighth word.
  task automatic test_counter_wrap();
    for (int i = 0; i < 11; i++) begin
      send_item(ModeAbsorb, 8'(i * 37));
    end
    send_item(ModeFinish, 8'h00);
    drain_digests();
  endtask

  // Finishes back to back must wait for the digest buffer.
  task automatic test_back_to_back_finish();
    send_message(8, 8'hff);
    send_item(ModeFinish, 8'h00);
    send_message(1, 8'h80);
    drain_digests();
  endtask

  // Receiver stops for a long stretch while bytes and finishes keep coming.
  task automatic test_output_backpressure();
    hold_request = 400;
    for (int m = 0; m < 5; m++) begin
      send_message($urandom_range(6), 8'($urandom_range(255)));
    end
    drain_digests();
  endtask

  // Full rate on both sides.
  task automatic test_unbroken_stream();
    sender_gaps = 1'b0;
    receiver_stalls = 1'b0;
    for (int m = 0; m < 6; m++) begin
      send_message($urandom_range(12), 8'($urandom_range(255)));
    end
    drain_digests();
    sender_gaps = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  // Random messages, mostly short, a few long, some empty.
  task automatic test_random_messages();
    int start_count;
    int len;
    start_count = items_sent;
    while (items_sent - start_count < RandomItems) begin
      case ($urandom_range(9))
        0: len = 0;
        1: len = $urandom_range(40, 17);
        default: len = $urandom_range(16, 1);
      endcase
      send_message(len, 8'($urandom_range(255)));
    end
    drain_digests();
  endtask

  // Main sequence.
  initial begin
    error_count = 0;
    items_sent = 0;
    hold_request = 0;
    sender_gaps = 1'b1;
    receiver_stalls = 1'b1;
    restart_hash();
    rst_ni = 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.mode      <= ModeAbsorb;
    in_ch.data_byte <= 8'h00;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_message();
    test_byte_extremes();
    test_counter_wrap();
    test_back_to_back_finish();
    test_output_backpressure();
    test_unbroken_stream();
    test_random_messages();

    // Let any stray output show up before the verdict.
    repeat (20) @(posedge clk_i);
    if (digest_queue.size() != 0) begin
      $display("%0d digest words never arrived", digest_queue.size());
      note_error();
    end
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
